>>> rtl/cpc_pkg.sv
// ----------------------------------------------------------------------------
// Coprime pair counter package
// Shared widths, controller states and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cpc_pkg;

   // Width of each number of a pair.
   localparam int VALUE_WIDTH = 32;
   // Width of the running counters.
   localparam int COUNT_WIDTH = 64;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_OUTPUT
   } cpc_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture a new pair
      logic step;    // one reduction step of the binary GCD
      logic finish;  // latch the result and update the counters
   } cpc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic finished;  // the result is known: the GCD, or a rejected pair
   } cpc_status_type;

endpackage

>>> rtl/coprime_pair_counter_top.sv
// ----------------------------------------------------------------------------
// Coprime pair counter
// Binary GCD of a pair of unsigned numbers with saturating counts of coprime
// pairs and of all pairs.
// ----------------------------------------------------------------------------
// Usage:
// An item on the req_ channel carries two unsigned numbers. The block works
// on one item at a time: req_ready is high only while it is idle. A pair
// whose numbers are both even is rejected with divisor 2 and no iteration.
// Otherwise the GCD is reduced by one shift or one subtract-and-halve per
// cycle in a single shared datapath. Each step removes at least one bit from
// the summed bit lengths of the two numbers, and the GCD left at the end
// keeps at least one, so there are at most 2*VALUE_WIDTH-1 (63) steps.
// The result is offered on rsp_valid in ST_OUTPUT, which follows the
// reduction in ST_RUN, and the next item can be taken in the cycle after
// the result is accepted. Each result carries the flag, the GCD and both
// running counts with this pair included.
// While the receiver stalls, the result is held unchanged and no new item
// is accepted. Reset clears the controller and both counters to zero; it
// needs no clearing pass.
// ----------------------------------------------------------------------------
module coprime_pair_counter_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cpc_pkg::VALUE_WIDTH-1:0] req_first_value,
   input  logic [cpc_pkg::VALUE_WIDTH-1:0] req_second_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_is_coprime,
   output logic [cpc_pkg::VALUE_WIDTH-1:0] rsp_divisor,
   output logic [cpc_pkg::COUNT_WIDTH-1:0] rsp_coprime_total,
   output logic [cpc_pkg::COUNT_WIDTH-1:0] rsp_pair_total
);

   cpc_pkg::cpc_cmd_type    cmd;
   cpc_pkg::cpc_status_type status;

   // Sequencing of one item.
   cpc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // GCD operands, result and counters.
   cpc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .first_value   (req_first_value),
      .second_value  (req_second_value),
      .is_coprime    (rsp_is_coprime),
      .divisor       (rsp_divisor),
      .coprime_total (rsp_coprime_total),
      .pair_total    (rsp_pair_total)
   );

endmodule

>>> rtl/cpc_datapath.sv
// ----------------------------------------------------------------------------
// Coprime pair counter datapath
// Holds the two operands of the binary GCD, performs one shift or one
// subtract-and-shift per step, and keeps the saturating pair counters.
// ----------------------------------------------------------------------------
module cpc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  cpc_pkg::cpc_cmd_type                cmd,
   output cpc_pkg::cpc_status_type             status,
   input  logic [cpc_pkg::VALUE_WIDTH-1:0]     first_value,
   input  logic [cpc_pkg::VALUE_WIDTH-1:0]     second_value,
   output logic                                is_coprime,
   output logic [cpc_pkg::VALUE_WIDTH-1:0]     divisor,
   output logic [cpc_pkg::COUNT_WIDTH-1:0]     coprime_total,
   output logic [cpc_pkg::COUNT_WIDTH-1:0]     pair_total
);

   logic [cpc_pkg::VALUE_WIDTH-1:0] a_ff, a_in;
   logic [cpc_pkg::VALUE_WIDTH-1:0] b_ff, b_in;
   logic                            reject_ff, reject_in;
   logic                            is_coprime_ff, is_coprime_in;
   logic [cpc_pkg::VALUE_WIDTH-1:0] divisor_ff, divisor_in;
   logic [cpc_pkg::COUNT_WIDTH-1:0] coprime_count_ff, coprime_count_in;
   logic [cpc_pkg::COUNT_WIDTH-1:0] pair_count_ff, pair_count_in;

   logic [cpc_pkg::VALUE_WIDTH-1:0] min_value;
   logic [cpc_pkg::VALUE_WIDTH-1:0] max_value;
   logic [cpc_pkg::VALUE_WIDTH-1:0] difference;
   logic [cpc_pkg::VALUE_WIDTH-1:0] gcd_value;
   logic                            gcd_is_one;

   // Order the operands and form their difference.
   always_comb begin
      if (a_ff > b_ff) begin
         min_value = b_ff;
         max_value = a_ff;
      end else begin
         min_value = a_ff;
         max_value = b_ff;
      end
      difference = max_value - min_value;
   end

   // With at least one odd operand the GCD is odd, so halving an even
   // operand keeps it. Once one operand reaches zero the other is the GCD.
   assign status.finished = reject_ff || (a_ff == '0) || (b_ff == '0);
   assign gcd_value = reject_ff ? cpc_pkg::VALUE_WIDTH'(2) : (a_ff | b_ff);
   assign gcd_is_one = (gcd_value == cpc_pkg::VALUE_WIDTH'(1));

   // Operand update: load, halve an even operand, or subtract and halve.
   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      reject_in = reject_ff;
      if (cmd.load) begin
         a_in      = first_value;
         b_in      = second_value;
         reject_in = !(first_value[0] || second_value[0]);
      end else if (cmd.step) begin
         if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else begin
            a_in = min_value;
            b_in = difference >> 1;
         end
      end
   end

   // Result latch and saturating counters.
   always_comb begin
      is_coprime_in    = is_coprime_ff;
      divisor_in       = divisor_ff;
      coprime_count_in = coprime_count_ff;
      pair_count_in    = pair_count_ff;
      if (cmd.finish) begin
         is_coprime_in = gcd_is_one;
         divisor_in    = gcd_value;
         if (pair_count_ff != '1) begin
            pair_count_in = pair_count_ff + cpc_pkg::COUNT_WIDTH'(1);
         end
         if (gcd_is_one && (coprime_count_ff != '1)) begin
            coprime_count_in = coprime_count_ff + cpc_pkg::COUNT_WIDTH'(1);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      reject_ff     <= reject_in;
      is_coprime_ff <= is_coprime_in;
      divisor_ff    <= divisor_in;
   end

   // Counters clear at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         coprime_count_ff <= '0;
         pair_count_ff    <= '0;
      end else begin
         coprime_count_ff <= coprime_count_in;
         pair_count_ff    <= pair_count_in;
      end
   end

   assign is_coprime    = is_coprime_ff;
   assign divisor       = divisor_ff;
   assign coprime_total = coprime_count_ff;
   assign pair_total    = pair_count_ff;

   // The coprime count can never pass the pair count.
   a_counts_ordered: assert property (@(posedge clock) disable iff (reset)
      coprime_count_ff <= pair_count_ff)
      else $error("coprime count exceeds pair count");

   // During a reduction at least one operand stays odd.
   a_one_odd: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && !reject_ff) |-> (a_ff[0] || b_ff[0]))
      else $error("both operands even during reduction");

   // A reported divisor is odd, or two for a rejected pair.
   a_divisor_form: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (divisor_ff[0] || (divisor_ff == cpc_pkg::VALUE_WIDTH'(2))))
      else $error("divisor is even and not the reject value");

endmodule

>>> rtl/cpc_controller.sv
// ----------------------------------------------------------------------------
// Coprime pair counter controller
// Sequences one item at a time: load, reduction steps until the datapath
// reports the GCD, then hold the result until it is taken.
// ----------------------------------------------------------------------------
module cpc_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output cpc_pkg::cpc_cmd_type    cmd,
   input  cpc_pkg::cpc_status_type status
);

   cpc_pkg::cpc_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cpc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cpc_pkg::ST_RUN;
            end
         end
         cpc_pkg::ST_RUN: begin
            if (status.finished) begin
               state_in = cpc_pkg::ST_OUTPUT;
            end
         end
         cpc_pkg::ST_OUTPUT: begin
            if (rsp_ready) begin
               state_in = cpc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cpc_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd        = '0;
      case (state_ff)
         cpc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         cpc_pkg::ST_RUN: begin
            cmd.step   = !status.finished;
            cmd.finish = status.finished;
         end
         cpc_pkg::ST_OUTPUT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A finished reduction always leads to a result offer.
   a_finish_offers: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished item not offered");

   // A held result blocks new items until it is taken.
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && !req_ready))
      else $error("stalled result dropped or new item taken");

endmodule

>>> dv/cpc_gcd_checker.sv
// ----------------------------------------------------------------------------
// Coprime pair counter checker
// Watches the request and result channels of the coprime pair counter. For
// every accepted pair it predicts the GCD, the coprime flag and both running
// counts. It then compares each accepted result, field by field, with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cpc_gcd_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [cpc_pkg::VALUE_WIDTH-1:0] req_first_value,
   input  logic [cpc_pkg::VALUE_WIDTH-1:0] req_second_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_is_coprime,
   input  logic [cpc_pkg::VALUE_WIDTH-1:0] rsp_divisor,
   input  logic [cpc_pkg::COUNT_WIDTH-1:0] rsp_coprime_total,
   input  logic [cpc_pkg::COUNT_WIDTH-1:0] rsp_pair_total,
   output int                              error_count,
   output int                              pending_count,
   output int                              checked_count,
   output int                              coprime_seen
);

   // One predicted result item.
   typedef struct packed {
      logic                            is_coprime;
      logic [cpc_pkg::VALUE_WIDTH-1:0] divisor;
      logic [cpc_pkg::COUNT_WIDTH-1:0] coprime_total;
      logic [cpc_pkg::COUNT_WIDTH-1:0] pair_total;
   } gcd_result_type;

   localparam logic [cpc_pkg::COUNT_WIDTH-1:0] COUNT_FULL = '1;
   localparam logic [cpc_pkg::VALUE_WIDTH-1:0] ONE_VALUE  = cpc_pkg::VALUE_WIDTH'(1);
   localparam logic [cpc_pkg::VALUE_WIDTH-1:0] REJECT_GCD = cpc_pkg::VALUE_WIDTH'(2);

   gcd_result_type                  pending_gcd_results[$];
   logic [cpc_pkg::COUNT_WIDTH-1:0] coprime_tally;
   logic [cpc_pkg::COUNT_WIDTH-1:0] pair_tally;
   int                              errors;
   int                              checked;
   int                              coprimes;

   // Binary GCD: pull out common factors of two, then shift and subtract.
   function automatic logic [cpc_pkg::VALUE_WIDTH-1:0] binary_gcd(
      logic [cpc_pkg::VALUE_WIDTH-1:0] a,
      logic [cpc_pkg::VALUE_WIDTH-1:0] b);
      int                              shift;
      logic [cpc_pkg::VALUE_WIDTH-1:0] swap;
      shift = 0;
      if (a == 0)
         return b;
      if (b == 0)
         return a;
      while (a[0] == 1'b0 && b[0] == 1'b0) begin
         a = a >> 1;
         b = b >> 1;
         shift++;
      end
      while (a[0] == 1'b0)
         a = a >> 1;
      while (b != 0) begin
         while (b[0] == 1'b0)
            b = b >> 1;
         if (a > b) begin
            swap = a;
            a    = b;
            b    = swap;
         end
         b = b - a;
      end
      return a << shift;
   endfunction

   // Saturating increment of a running count.
   function automatic logic [cpc_pkg::COUNT_WIDTH-1:0] count_up(
      logic [cpc_pkg::COUNT_WIDTH-1:0] c);
      return (c == COUNT_FULL) ? c : c + 1'b1;
   endfunction

   // Compare one field of a result and report a difference.
   task automatic check_field(input string field,
                              input logic [cpc_pkg::COUNT_WIDTH-1:0] expected,
                              input logic [cpc_pkg::COUNT_WIDTH-1:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, expected,
                  actual);
         errors++;
      end
   endtask

   // Prediction on each accepted pair, comparison on each accepted result.
   always @(posedge clock) begin
      gcd_result_type predicted;
      gcd_result_type oldest;
      if (reset) begin
         pending_gcd_results.delete();
         coprime_tally = '0;
         pair_tally    = '0;
         errors        = 0;
         checked       = 0;
         coprimes      = 0;
      end else begin
         if (req_valid && req_ready) begin
            // A pair with both numbers even is rejected without reduction.
            if ((req_first_value[0] | req_second_value[0]) == 1'b0)
               predicted.divisor = REJECT_GCD;
            else
               predicted.divisor = binary_gcd(req_first_value, req_second_value);
            predicted.is_coprime = (req_first_value[0] | req_second_value[0]) &&
                                   (predicted.divisor == ONE_VALUE);
            pair_tally = count_up(pair_tally);
            if (predicted.is_coprime) begin
               coprime_tally = count_up(coprime_tally);
               coprimes++;
            end
            predicted.coprime_total = coprime_tally;
            predicted.pair_total    = pair_tally;
            pending_gcd_results.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_gcd_results.size() == 0) begin
               $display("%0t: result item with nothing expected, divisor %0h", $time,
                        rsp_divisor);
               errors++;
            end else begin
               oldest = pending_gcd_results.pop_front();
               check_field("is_coprime", cpc_pkg::COUNT_WIDTH'(oldest.is_coprime),
                           cpc_pkg::COUNT_WIDTH'(rsp_is_coprime));
               check_field("divisor", cpc_pkg::COUNT_WIDTH'(oldest.divisor),
                           cpc_pkg::COUNT_WIDTH'(rsp_divisor));
               check_field("coprime_total", oldest.coprime_total, rsp_coprime_total);
               check_field("pair_total", oldest.pair_total, rsp_pair_total);
               checked++;
            end
         end
      end
      error_count   <= errors;
      pending_count <= pending_gcd_results.size();
      checked_count <= checked;
      coprime_seen  <= coprimes;
   end

endmodule

>>> dv/tb_coprime_pair_counter_top.sv
// ----------------------------------------------------------------------------
// Coprime pair counter testbench
// Drives pairs of numbers into the coprime pair counter: a directed set of
// corner pairs first, then a random mix of wide, small, shared-factor,
// zero and even pairs. Both channels idle at random; once the result side
// holds off for a long stretch, and the request side drains the block three times.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_coprime_pair_counter_top;

   localparam int RANDOM_ITEMS    = 830;
   localparam int LONG_HOLD       = 200;
   localparam int SETTLE_CYCLES   = 80;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [cpc_pkg::VALUE_WIDTH-1:0] req_first_value = '0;
   logic [cpc_pkg::VALUE_WIDTH-1:0] req_second_value = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_is_coprime;
   logic [cpc_pkg::VALUE_WIDTH-1:0] rsp_divisor;
   logic [cpc_pkg::COUNT_WIDTH-1:0] rsp_coprime_total;
   logic [cpc_pkg::COUNT_WIDTH-1:0] rsp_pair_total;

   int error_count;
   int pending_count;
   int checked_count;
   int coprime_seen;
   int items_sent = 0;
   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   bit long_hold_request = 1'b0;

   coprime_pair_counter_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_first_value   (req_first_value),
      .req_second_value  (req_second_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_coprime    (rsp_is_coprime),
      .rsp_divisor       (rsp_divisor),
      .rsp_coprime_total (rsp_coprime_total),
      .rsp_pair_total    (rsp_pair_total)
   );

   cpc_gcd_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_first_value   (req_first_value),
      .req_second_value  (req_second_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_coprime    (rsp_is_coprime),
      .rsp_divisor       (rsp_divisor),
      .rsp_coprime_total (rsp_coprime_total),
      .rsp_pair_total    (rsp_pair_total),
      .error_count       (error_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count),
      .coprime_seen      (coprime_seen)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Hard limit on the length of the run.
   initial begin
      #4000000;
      $display("tb_coprime_pair_counter_top failed");
      $finish;
   end

   // Offer one pair after a random gap and hold it until it is accepted.
   task automatic offer_pair(input logic [cpc_pkg::VALUE_WIDTH-1:0] a,
                             input logic [cpc_pkg::VALUE_WIDTH-1:0] b);
      int gap;
      gap = send_idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_first_value  <= a;
      req_second_value <= b;
      do
         @(posedge clock);
      while (!req_ready);
      items_sent++;
   endtask

   // Stop offering until every outstanding result item has come back.
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);
   endtask

   // Result side: random stalls per item, and one long hold-off on request.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            gap = recv_idle_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do
            @(posedge clock);
         while (!(rsp_valid && rsp_ready));
      end
   end

   // Stimulus and verdict.
   initial begin
      static logic [cpc_pkg::VALUE_WIDTH-1:0] dir_first[$] = '{
         32'h0, 32'h0, 32'h1, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 32'h2,
         32'hFFFFFFFE, 32'h80000000, 32'h1, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
         32'h6, 32'hC, 32'hB11924E1, 32'hAAAAAAAA, 32'h40000000, 32'h30,
         32'hFFFFFFFF, 32'h80000001};
      static logic [cpc_pkg::VALUE_WIDTH-1:0] dir_second[$] = '{
         32'h0, 32'h1, 32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h1, 32'h4,
         32'hFFFFFFFE, 32'h1, 32'h80000000, 32'h80000001, 32'hFFFFFFFE, 32'h55555555,
         32'h9, 32'h12, 32'h6D73E55F, 32'h55555555, 32'h3, 32'h3,
         32'h80000000, 32'h0};
      logic [cpc_pkg::VALUE_WIDTH-1:0] a;
      logic [cpc_pkg::VALUE_WIDTH-1:0] b;
      logic [cpc_pkg::VALUE_WIDTH-1:0] factor;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed corner pairs: zeros, all ones, both even, shared factors
      // and a long Fibonacci-like reduction.
      foreach (dir_first[i])
         offer_pair(dir_first[i], dir_second[i]);
      drain_block();

      // Random pairs in several flavors.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            send_idle_on = $urandom_range(0, 2) != 0;
            recv_idle_on = $urandom_range(0, 2) != 0;
         end
         if (n == 300)
            long_hold_request = 1'b1;
         if (n == 600)
            drain_block();
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               a = $urandom;
               b = $urandom;
            end
            4: begin
               a = $urandom_range(0, 40);
               b = $urandom_range(0, 40);
            end
            5: begin
               factor = $urandom_range(1, 2000) | 1;
               a = factor * $urandom_range(0, 1 << 20);
               b = factor * $urandom_range(0, 1 << 20);
            end
            6: begin
               a = 32'd1 << $urandom_range(0, 31);
               b = $urandom | 32'd1;
            end
            7: begin
               a = ($urandom_range(0, 1) != 0) ? '0 : $urandom;
               b = (a == 0) ? $urandom : '0;
            end
            8: begin
               a = ~cpc_pkg::VALUE_WIDTH'($urandom_range(0, 255));
               b = ~cpc_pkg::VALUE_WIDTH'($urandom_range(0, 255));
            end
            default: begin
               a = $urandom & ~32'd1;
               b = $urandom & ~32'd1;
            end
         endcase
         if ($urandom_range(0, 1) != 0)
            offer_pair(a, b);
         else
            offer_pair(b, a);
      end
      drain_block();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d pairs with random idling on both sides, a long result stall",
               items_sent);
      $display("and a full drain; %0d results checked, %0d of them coprime.", checked_count,
               coprime_seen);
      if (error_count == 0 && pending_count == 0)
         $display("tb_coprime_pair_counter_top passed");
      else
         $display("tb_coprime_pair_counter_top failed");
      $finish;
   end

endmodule

>>> coprime_pair_counter_top.f
rtl/cpc_pkg.sv
rtl/cpc_datapath.sv
rtl/cpc_controller.sv
rtl/coprime_pair_counter_top.sv
dv/cpc_gcd_checker.sv
dv/tb_coprime_pair_counter_top.sv
